[hdl/sgmpa_pkg.sv]
// ----------------------------------------------------------------------------
// sgmpa_pkg: shared definitions of the SGM path cost aggregation core
// Field widths, saturation limits, register indexes and the types passed
// between the control and the arithmetic of the core.
// ----------------------------------------------------------------------------
package sgmpa_pkg;

    // Field widths.
    localparam int COST_W     = 12;
    localparam int SUM_W      = 15;
    localparam int PATH_W     = 13;
    localparam int PEN_W      = 12;
    localparam int DISP_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Internal arithmetic widths.
    localparam int SMOOTH_W = PATH_W + 1;
    localparam int LSUM_W   = SMOOTH_W + 1;
    localparam int TOT_W    = SUM_W + 1;

    // Saturation limits.
    localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // Defaults of the top level parameters.
    localparam int DEF_MAX_DISPARITIES = 64;
    localparam int DEF_COST_BITS       = 12;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_PENALTY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_PENALTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISPARITIES   = 2'd2;

    // Reset values of the registers.
    localparam logic [PEN_W-1:0]  RST_SMALL_PENALTY = 12'd8;
    localparam logic [PEN_W-1:0]  RST_LARGE_PENALTY = 12'd32;
    localparam logic [DISP_W-1:0] RST_DISPARITIES   = 7'd64;

    // Previous pixel's path costs at d-1, d and d+1.
    typedef struct packed {
        logic [PATH_W-1:0] left;
        logic [PATH_W-1:0] center;
        logic [PATH_W-1:0] right;
    } t_window;

    // Which terms take part in the smoothness minimum.
    typedef struct packed {
        logic first;
        logic has_left;
        logic has_right;
    } t_step_ctl;

endpackage

[hdl/sgmpa_step_calc.sv]
// ----------------------------------------------------------------------------
// sgmpa_step_calc: path cost arithmetic of one disparity
// Smoothness minimum over the previous pixel's window, subtraction of the
// previous minimum, saturating path cost and saturating running sum.
// ----------------------------------------------------------------------------
module sgmpa_step_calc #(
    parameter int COST_BITS = sgmpa_pkg::DEF_COST_BITS
) (
    input  logic [sgmpa_pkg::COST_W-1:0] i_match_cost,
    input  logic [sgmpa_pkg::SUM_W-1:0]  i_partial_sum,
    input  sgmpa_pkg::t_step_ctl         i_ctl,
    input  sgmpa_pkg::t_window           i_win,
    input  logic [sgmpa_pkg::PATH_W-1:0] i_prev_min,
    input  logic [sgmpa_pkg::PEN_W-1:0]  i_small_pen,
    input  logic [sgmpa_pkg::PEN_W-1:0]  i_large_pen,
    output logic [sgmpa_pkg::PATH_W-1:0] o_path_cost,
    output logic [sgmpa_pkg::SUM_W-1:0]  o_updated_sum
);

    localparam logic [sgmpa_pkg::COST_W-1:0] CostMask =
        (COST_BITS >= sgmpa_pkg::COST_W) ? {sgmpa_pkg::COST_W{1'b1}}
                                         : sgmpa_pkg::COST_W'((1 << COST_BITS) - 1);

    logic [sgmpa_pkg::COST_W-1:0]   w_cost;
    logic [sgmpa_pkg::SMOOTH_W-1:0] w_pmin;
    logic [sgmpa_pkg::SMOOTH_W-1:0] w_smooth;
    logic [sgmpa_pkg::SMOOTH_W-1:0] w_cand_left;
    logic [sgmpa_pkg::SMOOTH_W-1:0] w_cand_right;
    logic [sgmpa_pkg::SMOOTH_W-1:0] w_cand_large;
    logic [sgmpa_pkg::SMOOTH_W-1:0] w_diff;
    logic [sgmpa_pkg::LSUM_W-1:0]   w_lsum;
    logic [sgmpa_pkg::TOT_W-1:0]    w_total;

    assign w_cost       = i_match_cost & CostMask;
    assign w_cand_left  = sgmpa_pkg::SMOOTH_W'(i_win.left) + sgmpa_pkg::SMOOTH_W'(i_small_pen);
    assign w_cand_right = sgmpa_pkg::SMOOTH_W'(i_win.right) + sgmpa_pkg::SMOOTH_W'(i_small_pen);
    assign w_cand_large = sgmpa_pkg::SMOOTH_W'(i_prev_min) + sgmpa_pkg::SMOOTH_W'(i_large_pen);

    always_comb begin
        if (i_ctl.first) begin
            w_smooth = '0;
            w_pmin   = '0;
        end else begin
            w_pmin   = sgmpa_pkg::SMOOTH_W'(i_prev_min);
            w_smooth = sgmpa_pkg::SMOOTH_W'(i_win.center);
            if (i_ctl.has_left && (w_cand_left < w_smooth)) begin
                w_smooth = w_cand_left;
            end
            if (i_ctl.has_right && (w_cand_right < w_smooth)) begin
                w_smooth = w_cand_right;
            end
            if (w_cand_large < w_smooth) begin
                w_smooth = w_cand_large;
            end
        end

        // A smoothness term below the stored minimum only occurs after the
        // disparity count changed between pixels; it then adds nothing.
        w_diff = (w_smooth >= w_pmin) ? (w_smooth - w_pmin) : '0;
        w_lsum = sgmpa_pkg::LSUM_W'(w_cost) + sgmpa_pkg::LSUM_W'(w_diff);

        if (w_lsum > sgmpa_pkg::LSUM_W'(sgmpa_pkg::PATH_MAX)) begin
            o_path_cost = sgmpa_pkg::PATH_MAX;
        end else begin
            o_path_cost = w_lsum[sgmpa_pkg::PATH_W-1:0];
        end

        w_total = sgmpa_pkg::TOT_W'(i_partial_sum) + sgmpa_pkg::TOT_W'(o_path_cost);
        if (w_total > sgmpa_pkg::TOT_W'(sgmpa_pkg::SUM_MAX)) begin
            o_updated_sum = sgmpa_pkg::SUM_MAX;
        end else begin
            o_updated_sum = w_total[sgmpa_pkg::SUM_W-1:0];
        end
    end

endmodule

[hdl/sgm_path_cost_aggregation_core.sv]
// ----------------------------------------------------------------------------
// sgm_path_cost_aggregation_core: one semi-global matching path step per item
// Streams matching costs of a pixel in disparity order and returns the new
// path cost and the updated running sum of every disparity.
// ----------------------------------------------------------------------------
// The core accepts one transaction per clock while the input is not
// stalled, and returns its result in the next cycle from an output
// register; a stall on the output stalls the input in the same cycle.
// The previous pixel's costs live in a two-bank memory with one read and
// one write port: the read port runs two disparities ahead of the current
// one, and a three-entry window supplies d-1, d and d+1 to the arithmetic.
// A write to the disparity count register triggers a window refetch of
// d-1, d and d+1 during which the input stalls. Memory reset is covered
// by per-entry valid bits, so no clearing pass follows reset.
module sgm_path_cost_aggregation_core #(
    parameter int MAX_DISPARITIES = sgmpa_pkg::DEF_MAX_DISPARITIES,
    parameter int COST_BITS       = sgmpa_pkg::DEF_COST_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_we,
    input  logic [sgmpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sgmpa_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sgmpa_pkg::COST_W-1:0]     i_match_cost,
    input  logic [sgmpa_pkg::SUM_W-1:0]      i_partial_sum,
    input  logic                             i_line_start,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sgmpa_pkg::PATH_W-1:0]     o_path_cost,
    output logic [sgmpa_pkg::SUM_W-1:0]      o_updated_sum,
    output logic                             o_pixel_done
);

    localparam int AW    = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;
    localparam int NW    = $clog2(MAX_DISPARITIES + 1);
    localparam int DEPTH = 2 ** AW;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_FETCH = 2'b10
    } t_fetch_state;

    // Configuration registers.
    logic [sgmpa_pkg::PEN_W-1:0]  r_small_pen;
    logic [sgmpa_pkg::PEN_W-1:0]  r_large_pen;
    logic [sgmpa_pkg::DISP_W-1:0] r_disp;

    // Pixel state.
    logic [AW-1:0]               r_counter;
    logic [AW-1:0]               n_counter;
    logic [sgmpa_pkg::PATH_W-1:0] r_prev_min;
    logic [sgmpa_pkg::PATH_W-1:0] r_run_min;
    sgmpa_pkg::t_window          r_win;
    logic [sgmpa_pkg::PATH_W-1:0] r_c0;
    logic [sgmpa_pkg::PATH_W-1:0] r_c1;

    // Per-index bank select, written-this-pixel and ever-valid bits.
    logic [DEPTH-1:0] r_sel;
    logic [DEPTH-1:0] n_sel;
    logic [DEPTH-1:0] r_wr;
    logic [DEPTH-1:0] n_wr;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;

    // Cost memory and its read path.
    logic [sgmpa_pkg::PATH_W-1:0] mem [0:2*DEPTH-1];
    logic [sgmpa_pkg::PATH_W-1:0] r_mem_q;
    logic [sgmpa_pkg::PATH_W-1:0] r_fwd_data;
    logic                         r_fwd;
    logic                         r_rd_vld;
    logic [sgmpa_pkg::PATH_W-1:0] w_rd;
    logic [AW-1:0]                w_ridx;
    logic [AW:0]                  w_raddr;
    logic [AW:0]                  w_waddr;

    // Refetch sequencer.
    t_fetch_state r_state;
    logic [1:0]   r_fstep;

    // Output register.
    logic                         r_out_valid;
    logic [sgmpa_pkg::PATH_W-1:0] r_path_cost;
    logic [sgmpa_pkg::SUM_W-1:0]  r_updated_sum;
    logic                         r_pixel_done;

    // Current item.
    logic [NW-1:0]                w_n;
    logic [NW-1:0]                w_n_m1;
    logic                         w_last;
    logic [AW-1:0]                w_d;
    logic [AW-1:0]                w_next_eff;
    logic                         w_fire;
    sgmpa_pkg::t_step_ctl         w_ctl;
    logic [sgmpa_pkg::PATH_W-1:0] w_lcost;
    logic [sgmpa_pkg::SUM_W-1:0]  w_sum;
    logic [sgmpa_pkg::PATH_W-1:0] w_new_min;

    // Effective disparity count.
    always_comb begin
        if (32'(r_disp) > 32'(MAX_DISPARITIES)) begin
            w_n = NW'(MAX_DISPARITIES);
        end else if (r_disp < 7'd2) begin
            w_n = NW'(2);
        end else begin
            w_n = NW'(r_disp);
        end
    end

    assign w_n_m1 = w_n - NW'(1);

    // A counter at or past the last disparity makes this the pixel's last item.
    assign w_last = (NW'(r_counter) >= w_n_m1);
    assign w_d    = w_last ? AW'(w_n_m1) : r_counter;

    assign w_ctl.first     = i_line_start;
    assign w_ctl.has_left  = (w_d != '0);
    assign w_ctl.has_right = ((NW'(w_d) + NW'(1)) < w_n);

    assign o_in_stall = (r_state != ST_RUN) || (r_out_valid && i_out_stall);
    assign w_fire     = i_in_valid && !o_in_stall;

    sgmpa_step_calc #(
        .COST_BITS (COST_BITS)
    ) u_calc (
        .i_match_cost  (i_match_cost),
        .i_partial_sum (i_partial_sum),
        .i_ctl         (w_ctl),
        .i_win         (r_win),
        .i_prev_min    (r_prev_min),
        .i_small_pen   (r_small_pen),
        .i_large_pen   (r_large_pen),
        .o_path_cost   (w_lcost),
        .o_updated_sum (w_sum)
    );

    assign w_new_min = (w_lcost < r_run_min) ? w_lcost : r_run_min;

    always_comb begin
        if (!w_fire) begin
            n_counter = r_counter;
        end else if (w_last) begin
            n_counter = '0;
        end else begin
            n_counter = w_d + AW'(1);
        end
        w_next_eff = (NW'(n_counter) >= w_n_m1) ? AW'(w_n_m1) : n_counter;
    end

    // At the end of a pixel every index written during it switches its bank,
    // so the current costs become the previous ones without a copy.
    always_comb begin
        n_sel = r_sel;
        n_vld = r_vld;
        n_wr  = r_wr;
        if (w_fire) begin
            if (w_last) begin
                n_wr = '0;
                for (int i = 0; i < DEPTH; i++) begin
                    if (r_wr[i] || (AW'(i) == w_d)) begin
                        n_sel[i] = ~r_sel[i];
                        n_vld[i] = 1'b1;
                    end
                end
            end else begin
                n_wr[w_d] = 1'b1;
            end
        end
    end

    // The read port fetches the previous cost two disparities ahead, or
    // walks the window positions during a refetch.
    always_comb begin
        if (r_state == ST_FETCH) begin
            w_ridx = w_d - AW'(1) + AW'(r_fstep);
        end else begin
            w_ridx = w_next_eff + AW'(2);
        end
        w_raddr = {n_sel[w_ridx], w_ridx};
        w_waddr = {~r_sel[w_d], w_d};
    end

    assign w_rd = !r_rd_vld ? '0 : (r_fwd ? r_fwd_data : r_mem_q);

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            mem[w_waddr] <= w_lcost;
        end
        r_mem_q    <= mem[w_raddr];
        r_fwd_data <= w_lcost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_fwd    <= w_fire && (w_waddr == w_raddr);
            r_rd_vld <= n_vld[w_ridx];
        end
    end

    // Configuration registers and refetch sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_pen <= sgmpa_pkg::RST_SMALL_PENALTY;
            r_large_pen <= sgmpa_pkg::RST_LARGE_PENALTY;
            r_disp      <= sgmpa_pkg::RST_DISPARITIES;
            r_state     <= ST_RUN;
            r_fstep     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sgmpa_pkg::REG_SMALL_PENALTY: begin
                        r_small_pen <= i_cfg_data[sgmpa_pkg::PEN_W-1:0];
                    end
                    sgmpa_pkg::REG_LARGE_PENALTY: begin
                        r_large_pen <= i_cfg_data[sgmpa_pkg::PEN_W-1:0];
                    end
                    sgmpa_pkg::REG_DISPARITIES: begin
                        r_disp <= i_cfg_data[sgmpa_pkg::DISP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cfg_we && (i_cfg_index == sgmpa_pkg::REG_DISPARITIES)) begin
                r_state <= ST_FETCH;
                r_fstep <= '0;
            end else begin
                case (r_state)
                    ST_FETCH: begin
                        r_fstep <= r_fstep + 2'd1;
                        if (r_fstep == 2'd3) begin
                            r_state <= ST_RUN;
                        end
                    end
                    default: begin
                        r_state <= ST_RUN;
                    end
                endcase
            end
        end
    end

    // Pixel state and window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_prev_min <= '0;
            r_run_min  <= sgmpa_pkg::PATH_MAX;
            r_win      <= '0;
            r_sel      <= '0;
            r_wr       <= '0;
            r_vld      <= '0;
        end else begin
            r_counter <= n_counter;
            r_sel     <= n_sel;
            r_wr      <= n_wr;
            r_vld     <= n_vld;

            if (r_state == ST_FETCH) begin
                case (r_fstep)
                    2'd1:    r_win.left   <= w_rd;
                    2'd2:    r_win.center <= w_rd;
                    2'd3:    r_win.right  <= w_rd;
                    default: begin
                    end
                endcase
            end else if (w_fire) begin
                if (w_last) begin
                    r_prev_min   <= w_new_min;
                    r_run_min    <= sgmpa_pkg::PATH_MAX;
                    // Disparities zero and one are written in every pixel.
                    r_win.center <= r_c0;
                    r_win.right  <= (w_d == AW'(1)) ? w_lcost : r_c1;
                end else begin
                    r_run_min    <= w_new_min;
                    r_win.left   <= r_win.center;
                    r_win.center <= r_win.right;
                    r_win.right  <= w_rd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && (w_d == '0)) begin
            r_c0 <= w_lcost;
        end
        if (w_fire && (w_d == AW'(1))) begin
            r_c1 <= w_lcost;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_path_cost   <= w_lcost;
            r_updated_sum <= w_sum;
            r_pixel_done  <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_path_cost   = r_path_cost;
    assign o_updated_sum = r_updated_sum;
    assign o_pixel_done  = r_pixel_done;

    // A pixel in progress has always written its first disparity.
    a_first_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_counter != '0) |-> r_wr[0])
        else $error("pixel in progress without disparity zero written");

    a_pixel_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last) |=> ((r_counter == '0) && (r_wr == '0)))
        else $error("pixel end did not clear counter and written bits");

    a_run_min_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_last) |=> (r_run_min <= $past(w_lcost)))
        else $error("running minimum above the latest path cost");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out_valid && (r_pixel_done == $past(w_last))))
        else $error("accepted transaction did not load the output register");

    a_fetch_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == sgmpa_pkg::REG_DISPARITIES)) |=> o_in_stall)
        else $error("input open right after a disparity count write");

endmodule

[verif/sgm_path_cost_aggregation_core_tb.sv]
// ----------------------------------------------------------------------------
// sgm_path_cost_aggregation_core_tb: self-checking bench of the path cost core
// Streams matching costs through the core under random input gaps and output
// stalls, predicts every path cost and running sum from a behavioral copy of
// the path step, and compares each result in order of arrival.
// ----------------------------------------------------------------------------
module sgm_path_cost_aggregation_core_tb;

    localparam int MAX_DISP     = sgmpa_pkg::DEF_MAX_DISPARITIES;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 150;
    localparam int RANDOM_ITEMS = 380;

    // The fourth register slot is not mapped to anything.
    localparam logic [sgmpa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam logic [sgmpa_pkg::COST_W-1:0] COST_TOP = {sgmpa_pkg::COST_W{1'b1}};

    typedef struct packed {
        logic [sgmpa_pkg::PATH_W-1:0] path_cost;
        logic [sgmpa_pkg::SUM_W-1:0]  updated_sum;
        logic                         pixel_done;
    } t_path_result;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [sgmpa_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [sgmpa_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [sgmpa_pkg::COST_W-1:0]     i_match_cost;
    logic [sgmpa_pkg::SUM_W-1:0]      i_partial_sum;
    logic                             i_line_start;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic [sgmpa_pkg::PATH_W-1:0]     o_path_cost;
    logic [sgmpa_pkg::SUM_W-1:0]      o_updated_sum;
    logic                             o_pixel_done;

    // Shadow of the core's registers and path state.
    logic [sgmpa_pkg::PEN_W-1:0]  small_pen;
    logic [sgmpa_pkg::PEN_W-1:0]  large_pen;
    logic [sgmpa_pkg::DISP_W-1:0] disp_setting;
    logic [sgmpa_pkg::PATH_W-1:0] prior_costs [MAX_DISP];
    logic [sgmpa_pkg::PATH_W-1:0] fresh_costs [MAX_DISP];
    logic [sgmpa_pkg::PATH_W-1:0] prior_min;
    logic [sgmpa_pkg::PATH_W-1:0] pixel_min;
    int                           disp_idx;

    t_path_result pending_results[$];
    int           mismatch_count;
    int           items_sent;
    int           hold_requests;
    bit           tx_idle_en;
    bit           rx_idle_en;

    sgm_path_cost_aggregation_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_match_cost  (i_match_cost),
        .i_partial_sum (i_partial_sum),
        .i_line_start  (i_line_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_path_cost   (o_path_cost),
        .o_updated_sum (o_updated_sum),
        .o_pixel_done  (o_pixel_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int active_disparities();
        if (disp_setting < 2) return 2;
        if (disp_setting > MAX_DISP) return MAX_DISP;
        return int'(disp_setting);
    endfunction

    // One path step: smoothness term from the previous pixel only, then the
    // current pixel's costs replace the previous ones at its last disparity.
    function automatic t_path_result aggregate_step(
        input logic [sgmpa_pkg::COST_W-1:0] cost,
        input logic [sgmpa_pkg::SUM_W-1:0]  psum,
        input logic                         first
    );
        t_path_result res;
        int   n;
        int   d;
        int   base;
        int   smooth;
        int   t;
        int   lval;
        int   total;
        logic last;

        n    = active_disparities();
        d    = disp_idx;
        last = 1'b0;
        if (d >= n - 1) begin
            d    = n - 1;
            last = 1'b1;
        end
        if (first) begin
            base   = 0;
            smooth = 0;
        end else begin
            base   = int'(prior_min);
            smooth = int'(prior_costs[d]);
            if (d > 0) begin
                t = int'(prior_costs[d - 1]) + int'(small_pen);
                if (t < smooth) smooth = t;
            end
            if (d + 1 < n) begin
                t = int'(prior_costs[d + 1]) + int'(small_pen);
                if (t < smooth) smooth = t;
            end
            t = base + int'(large_pen);
            if (t < smooth) smooth = t;
        end
        // A minimum left over from a different disparity count can exceed
        // the smoothness term; the difference then counts as zero.
        lval = int'(cost) + ((smooth >= base) ? smooth - base : 0);
        if (lval > int'(sgmpa_pkg::PATH_MAX)) lval = int'(sgmpa_pkg::PATH_MAX);
        total = int'(psum) + lval;
        if (total > int'(sgmpa_pkg::SUM_MAX)) total = int'(sgmpa_pkg::SUM_MAX);

        fresh_costs[d] = lval[sgmpa_pkg::PATH_W-1:0];
        if (lval[sgmpa_pkg::PATH_W-1:0] < pixel_min) pixel_min = lval[sgmpa_pkg::PATH_W-1:0];
        if (last) begin
            prior_costs = fresh_costs;
            prior_min   = pixel_min;
            pixel_min   = sgmpa_pkg::PATH_MAX;
            disp_idx    = 0;
        end else begin
            disp_idx = d + 1;
        end

        res.path_cost   = lval[sgmpa_pkg::PATH_W-1:0];
        res.updated_sum = total[sgmpa_pkg::SUM_W-1:0];
        res.pixel_done  = last;
        return res;
    endfunction

    function automatic logic [sgmpa_pkg::COST_W-1:0] pick_cost();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return COST_TOP;
            2:       return sgmpa_pkg::COST_W'($urandom_range(0, 31));
            default: return sgmpa_pkg::COST_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [sgmpa_pkg::SUM_W-1:0] pick_sum();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return sgmpa_pkg::SUM_MAX;
            2:       return sgmpa_pkg::SUM_W'($urandom_range(28000, 32767));
            default: return sgmpa_pkg::SUM_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [sgmpa_pkg::CFG_DATA_W-1:0] pick_penalty();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return {sgmpa_pkg::CFG_DATA_W{1'b1}};
            2, 3:    return sgmpa_pkg::CFG_DATA_W'($urandom_range(0, 63));
            default: return sgmpa_pkg::CFG_DATA_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic write_reg(input logic [sgmpa_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [sgmpa_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            sgmpa_pkg::REG_SMALL_PENALTY: small_pen    = data[sgmpa_pkg::PEN_W-1:0];
            sgmpa_pkg::REG_LARGE_PENALTY: large_pen    = data[sgmpa_pkg::PEN_W-1:0];
            sgmpa_pkg::REG_DISPARITIES:   disp_setting = data[sgmpa_pkg::DISP_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Valid stays high from one transaction to the next unless a gap is drawn.
    task automatic send_cost_item(input logic [sgmpa_pkg::COST_W-1:0] cost,
                                  input logic [sgmpa_pkg::SUM_W-1:0]  psum,
                                  input logic                         first);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_match_cost  <= cost;
        i_partial_sum <= psum;
        i_line_start  <= first;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(aggregate_step(cost, psum, first));
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Whole pixels at the current count; now and then a new path starts, and
    // a few transactions carry a flipped line start flag.
    task automatic send_pixels(input int pixel_total);
        int   n;
        logic new_path;
        logic ls;

        n = active_disparities();
        repeat (pixel_total) begin
            new_path = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++) begin
                ls = new_path;
                if ($urandom_range(0, 15) == 0) ls = ~ls;
                send_cost_item(pick_cost(), pick_sum(), ls);
            end
        end
    endtask

    task automatic test_directed_cases();
        // Reset values: D = 64, P1 = 8, P2 = 32.
        send_cost_item(COST_TOP, sgmpa_pkg::SUM_MAX, 1'b0);
        send_cost_item('0, '0, 1'b0);
        send_cost_item(12'd1234, 15'd100, 1'b0);
        drain_results();

        // The counter already stands past the new count, so the next
        // transaction closes the pixel.
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'd3);
        write_reg(sgmpa_pkg::REG_SMALL_PENALTY, 12'hFFF);
        write_reg(sgmpa_pkg::REG_LARGE_PENALTY, 12'hFFF);
        send_cost_item(12'd7, 15'd0, 1'b0);
        send_cost_item(COST_TOP, sgmpa_pkg::SUM_MAX, 1'b1);
        send_cost_item('0, '0, 1'b1);
        send_cost_item(COST_TOP, sgmpa_pkg::SUM_MAX, 1'b1);
        repeat (3) send_cost_item('0, 15'd5, 1'b0);
        repeat (3) send_cost_item(COST_TOP, sgmpa_pkg::SUM_MAX, 1'b0);
        drain_results();

        // A count of zero acts as two; the unmapped slot must change nothing.
        write_reg(sgmpa_pkg::REG_SMALL_PENALTY, 12'd0);
        write_reg(sgmpa_pkg::REG_LARGE_PENALTY, 12'd0);
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'd0);
        write_reg(REG_UNMAPPED, 12'hFFF);
        send_cost_item(12'd100, 15'd1, 1'b0);
        send_cost_item('0, 15'd2, 1'b0);
        send_cost_item(COST_TOP, 15'd3, 1'b0);
        send_cost_item(12'd5, sgmpa_pkg::SUM_MAX, 1'b0);
        drain_results();

        // Only the low seven data bits count: this selects 127, above the maximum.
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'hFFF);
        write_reg(sgmpa_pkg::REG_SMALL_PENALTY, 12'd1);
        write_reg(sgmpa_pkg::REG_LARGE_PENALTY, 12'hFFF);
        send_cost_item(12'd40, 15'd0, 1'b0);
        send_cost_item(12'd3, 15'd0, 1'b0);
        send_cost_item(12'd900, 15'd0, 1'b0);
        send_cost_item(12'd2, 15'd0, 1'b0);
        drain_results();

        // Shrink the count mid-pixel, then grow it so that stale costs and a
        // stale minimum meet.
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'd2);
        send_cost_item(12'd600, 15'd0, 1'b0);
        send_cost_item(12'd700, 15'd0, 1'b0);
        drain_results();
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'd6);
        repeat (6) send_cost_item('0, 15'd0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_sequences();
        int                               start_count;
        int                               n;
        logic [sgmpa_pkg::CFG_DATA_W-1:0] dval;

        start_count = items_sent;
        while (items_sent < start_count + RANDOM_ITEMS) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0)
                write_reg(sgmpa_pkg::REG_SMALL_PENALTY, pick_penalty());
            if ($urandom_range(0, 2) != 0)
                write_reg(sgmpa_pkg::REG_LARGE_PENALTY, pick_penalty());
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       dval = sgmpa_pkg::CFG_DATA_W'($urandom_range(0, 1));
                    1:       dval = sgmpa_pkg::CFG_DATA_W'(MAX_DISP);
                    2:       dval = sgmpa_pkg::CFG_DATA_W'($urandom_range(MAX_DISP + 1, 127));
                    3:       dval = sgmpa_pkg::CFG_DATA_W'(($urandom & 32'hF80) |
                                                           $urandom_range(2, 8));
                    default: dval = sgmpa_pkg::CFG_DATA_W'($urandom_range(2, 8));
                endcase
                write_reg(sgmpa_pkg::REG_DISPARITIES, dval);
            end
            n = active_disparities();
            send_pixels(($urandom_range(20, 60) + n - 1) / n);
            // Some phases end mid-pixel, with a broken line start pattern.
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, n - 1))
                    send_cost_item(pick_cost(), pick_sum(), 1'($urandom_range(0, 1)));
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'd5);
        // The receiver holds off while the sender keeps offering transactions.
        hold_requests++;
        send_pixels(8);
        drain_results();
    endtask

    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_reg(sgmpa_pkg::REG_SMALL_PENALTY, pick_penalty());
        write_reg(sgmpa_pkg::REG_LARGE_PENALTY, pick_penalty());
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'd4);
        send_pixels(20);
        drain_results();
        write_reg(sgmpa_pkg::REG_DISPARITIES, 12'd64);
        send_pixels(1);
        drain_results();
    endtask

    // Output stall: random bursts, or one long hold when a test asks for it.
    initial begin : rx_stall_gen
        int burst_left;
        int hold_left;
        int holds_seen;

        burst_left  = 0;
        hold_left   = 0;
        holds_seen  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(0, 12);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string field, input int want, input int got);
        if (mismatch_count < 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_path_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("result with no pending transaction: path_cost %0d", o_path_cost);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_path_cost !== want.path_cost)
                    report_mismatch("path_cost", want.path_cost, o_path_cost);
                if (o_updated_sum !== want.updated_sum)
                    report_mismatch("updated_sum", want.updated_sum, o_updated_sum);
                if (o_pixel_done !== want.pixel_done)
                    report_mismatch("pixel_done", want.pixel_done, o_pixel_done);
            end
        end
    end

    initial begin
        mismatch_count = 0;
        items_sent     = 0;
        hold_requests  = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        small_pen      = sgmpa_pkg::RST_SMALL_PENALTY;
        large_pen      = sgmpa_pkg::RST_LARGE_PENALTY;
        disp_setting   = sgmpa_pkg::RST_DISPARITIES;
        for (int k = 0; k < MAX_DISP; k++) begin
            prior_costs[k] = '0;
            fresh_costs[k] = '0;
        end
        prior_min = '0;
        pixel_min = sgmpa_pkg::PATH_MAX;
        disp_idx  = 0;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_match_cost  <= '0;
        i_partial_sum <= '0;
        i_line_start  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_sequences();
        test_output_backpressure();
        test_steady_stream();

        drain_results();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
